[src/grouped_bitmap_inode_allocator_defines.svh]
// assertion macros used by the inode allocator top level
`ifndef GROUPED_BITMAP_INODE_ALLOCATOR_DEFINES_SVH
`define GROUPED_BITMAP_INODE_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// general property, checking off while reset is high
`define GBIA_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// same-cycle implication, checking off while reset is high
`define GBIA_ASSERT_IMPLY(lbl, clk_sig, rst_sig, ante, cons, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

`else

`define GBIA_ASSERT(lbl, clk_sig, rst_sig, prop, msg)

`define GBIA_ASSERT_IMPLY(lbl, clk_sig, rst_sig, ante, cons, msg)

`endif

`endif

[src/gbia_pkg.sv]
// shared constants and types of the inode allocator
package gbia_pkg;

  localparam int INODE_W    = 18;
  localparam int STATUS_W   = 3;
  localparam int GROUPS_W   = 5;
  localparam int COUNT_W    = 14;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 18;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NONE     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RESERVED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ALREADY  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_GROUPS     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 1'b1;

  localparam logic [GROUPS_W-1:0] GROUPS_RESET     = 5'd16;
  localparam logic [INODE_W-1:0]  FIRST_FREE_RESET = 18'd11;

  // divisor select of the constant divider
  localparam logic DIV_GROUP = 1'b0;
  localparam logic DIV_WORD  = 1'b1;

  typedef struct packed {
    logic start;
    logic sel;
  } div_ctl_t;

endpackage

[src/gbia_if.sv]
// request and response channel interfaces of the inode allocator
interface gbia_in_if;
  import gbia_pkg::*;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [INODE_W-1:0] inode_number;
  modport source (output valid, mode, inode_number, input ready);
  modport sink (input valid, mode, inode_number, output ready);
endinterface

interface gbia_out_if;
  import gbia_pkg::*;
  logic                valid;
  logic                ready;
  logic [INODE_W-1:0]  allocated_inode;
  logic [STATUS_W-1:0] status;
  modport source (output valid, allocated_inode, status, input ready);
  modport sink (input valid, allocated_inode, status, output ready);
endinterface

[src/grouped_bitmap_inode_allocator.sv]
// grouped bitmap inode allocator, top level
//
//  channel  dir  handshake        payload
//  req      in   valid / ready    mode, inode_number
//  rsp      out  valid / ready    allocated_inode, status
//  cfg      in   cfg_we           cfg_index, cfg_data
//
// reset: a clearing pass writes every bitmap word and group counter; req is not ready
// until it ends, cfg writes go in; free: early answer if reserved or out of range, else
// a divide into group and word, then a read, and a clear if set; allocate: early answer
// if the total count shows no room, else a walk over the groups that skips reserved ones,
// reads each group counter and scans words on the single bitmap read port (256 per group)
// stalls: the next request is taken while a result waits in rsp, then holds at output
`include "grouped_bitmap_inode_allocator_defines.svh"

module grouped_bitmap_inode_allocator #(
  parameter int GROUP_COUNT      = 16,
  parameter int INODES_PER_GROUP = 8192,
  parameter int WORD_BITS        = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [gbia_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gbia_pkg::CFG_DATA_W-1:0]   cfg_data,
  gbia_in_if.sink                           req,
  gbia_out_if.source                        rsp
);
  import gbia_pkg::*;

  localparam int TOTAL_BITS = GROUP_COUNT * INODES_PER_GROUP;
  localparam int WORD_COUNT = (TOTAL_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int CLR_N      = (WORD_COUNT > GROUP_COUNT) ? WORD_COUNT : GROUP_COUNT;
  localparam int A_W        = ($clog2(TOTAL_BITS + 1) > INODE_W) ?
                              $clog2(TOTAL_BITS + 1) : INODE_W;
  localparam int WA_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int GA_W       = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
  localparam int GN_W       = $clog2(GROUP_COUNT + 1);
  localparam int CP_W       = (CLR_N > 1) ? $clog2(CLR_N) : 1;
  localparam int OFF_W      = $clog2(WORD_BITS);
  localparam int REM_W      = $clog2(INODES_PER_GROUP + 1);
  localparam int IPG_WQ     = INODES_PER_GROUP / WORD_BITS;
  localparam int IPG_WR     = INODES_PER_GROUP % WORD_BITS;

  typedef enum logic [13:0] {
    S_CLEAR = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_LOAD  = 14'b00000000000100,
    S_CHECK = 14'b00000000001000,
    S_DG    = 14'b00000000010000,
    S_DW    = 14'b00000000100000,
    S_CG    = 14'b00000001000000,
    S_CW    = 14'b00000010000000,
    S_FRD   = 14'b00000100000000,
    S_FCHK  = 14'b00001000000000,
    S_GSEL  = 14'b00010000000000,
    S_GCNT  = 14'b00100000000000,
    S_SCAN  = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  state_t state;

  // configuration
  logic [GROUPS_W-1:0] groups_in_use;
  logic [INODE_W-1:0]  first_free_inode;

  // storage
  logic [WORD_BITS-1:0] bitmap [WORD_COUNT];
  logic [COUNT_W-1:0]   group_cnt [GROUP_COUNT];
  logic [INODE_W-1:0]   total_used;

  // item context
  logic                 mode_r;
  logic [INODE_W-1:0]   num_r;
  logic [A_W-1:0]       xs;
  logic [GN_W-1:0]      ng_r;
  logic [A_W-1:0]       cap;
  logic [A_W-1:0]       fg;
  logic [A_W-1:0]       fw;
  logic [OFF_W-1:0]     foff;

  // group walk and word scan
  logic [GN_W-1:0]      g;
  logic [A_W-1:0]       base;
  logic [A_W-1:0]       base_word;
  logic [OFF_W-1:0]     base_off;
  logic [A_W-1:0]       b_cur;
  logic [A_W-1:0]       w;
  logic [OFF_W-1:0]     woff;
  logic [REM_W-1:0]     rem;
  logic [COUNT_W-1:0]   cnt_hold;
  logic [CP_W-1:0]      clr_ptr;

  logic [INODE_W-1:0]   res_inode;
  logic [STATUS_W-1:0]  res_status;

  // memory ports
  logic [WA_W-1:0]      bm_raddr;
  logic [WORD_BITS-1:0] bm_rdata;
  logic                 bm_we;
  logic [WA_W-1:0]      bm_waddr;
  logic [WORD_BITS-1:0] bm_wdata;
  logic [GA_W-1:0]      cnt_raddr;
  logic [COUNT_W-1:0]   cnt_rdata;
  logic                 cnt_we;
  logic [GA_W-1:0]      cnt_waddr;
  logic [COUNT_W-1:0]   cnt_wdata;

  // divider
  div_ctl_t             div_ctl;
  logic                 div_valid;
  logic [A_W-1:0]       div_q;
  logic [A_W-1:0]       div_r;

  // combinational helpers
  logic [GN_W-1:0]      ng_eff;
  logic [A_W-1:0]       start_bit;
  logic [A_W-1:0]       start_word;
  logic [OFF_W-1:0]     start_off;
  logic [REM_W-1:0]     start_rem;
  logic [OFF_W:0]       off_sum;
  logic [OFF_W-1:0]     nb_off;
  logic [A_W-1:0]       nb_word;
  logic [OFF_W:0]       avail;
  logic                 rem_fits;
  logic [OFF_W:0]       hi;
  logic [WORD_BITS-1:0] free_bits;
  logic                 hit;
  logic [OFF_W-1:0]     pos;
  logic [A_W-1:0]       b_hit;
  logic                 bit_on;
  logic                 grp_full;

  gbia_div #(
    .N  (A_W),
    .D0 (INODES_PER_GROUP),
    .D1 (WORD_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .ctl   (div_ctl),
    .x     (xs),
    .valid (div_valid),
    .q     (div_q),
    .r     (div_r)
  );

  assign req.ready = (state == S_IDLE);

  always_comb begin
    div_ctl.start = (state == S_DG) || (state == S_DW);
    div_ctl.sel   = (state == S_DW) ? DIV_WORD : DIV_GROUP;

    ng_eff = (32'(groups_in_use) > GROUP_COUNT) ? GN_W'(GROUP_COUNT) :
             GN_W'(groups_in_use);

    // scan start: the reserved boundary inside its own group, else the group base
    if (A_W'(g) == fg) begin
      start_bit  = xs;
      start_word = fw;
      start_off  = foff;
    end else begin
      start_bit  = base;
      start_word = base_word;
      start_off  = base_off;
    end
    start_rem = REM_W'(base + A_W'(INODES_PER_GROUP) - start_bit);
    grp_full  = 32'(cnt_rdata) >= INODES_PER_GROUP;

    // base word and offset of the next group
    off_sum = (OFF_W + 1)'(base_off) + (OFF_W + 1)'(IPG_WR);
    if (32'(off_sum) >= WORD_BITS) begin
      nb_off  = OFF_W'(32'(off_sum) - WORD_BITS);
      nb_word = base_word + A_W'(IPG_WQ + 1);
    end else begin
      nb_off  = OFF_W'(off_sum);
      nb_word = base_word + A_W'(IPG_WQ);
    end

    // lowest clear bit of the word inside the live window
    avail    = (OFF_W + 1)'(WORD_BITS) - (OFF_W + 1)'(woff);
    rem_fits = 32'(rem) <= 32'(avail);
    hi       = (OFF_W + 1)'(woff) + (OFF_W + 1)'(rem);
    for (int p = 0; p < WORD_BITS; p++) begin
      free_bits[p] = !bm_rdata[p] && ((OFF_W + 1)'(p) >= (OFF_W + 1)'(woff)) &&
                     (!rem_fits || ((OFF_W + 1)'(p) < hi));
    end
    hit = |free_bits;
    pos = '0;
    for (int p = WORD_BITS - 1; p >= 0; p--) begin
      if (free_bits[p]) begin
        pos = OFF_W'(p);
      end
    end
    b_hit  = b_cur - A_W'(woff) + A_W'(pos);
    bit_on = |(bm_rdata & (WORD_BITS'(1) << foff));

    // bitmap read address
    unique case (state)
      S_GCNT:  bm_raddr = start_word[WA_W-1:0];
      S_SCAN:  bm_raddr = WA_W'(w + A_W'(1));
      S_FRD:   bm_raddr = fw[WA_W-1:0];
      default: bm_raddr = w[WA_W-1:0];
    endcase

    // bitmap write
    bm_we    = 1'b0;
    bm_waddr = w[WA_W-1:0];
    bm_wdata = bm_rdata | (WORD_BITS'(1) << pos);
    cnt_we    = 1'b0;
    cnt_waddr = g[GA_W-1:0];
    cnt_wdata = cnt_hold + COUNT_W'(1);
    unique case (state)
      S_CLEAR: begin
        bm_we     = 32'(clr_ptr) < WORD_COUNT;
        bm_waddr  = clr_ptr[WA_W-1:0];
        bm_wdata  = '0;
        cnt_we    = 32'(clr_ptr) < GROUP_COUNT;
        cnt_waddr = clr_ptr[GA_W-1:0];
        cnt_wdata = '0;
      end
      S_SCAN: begin
        bm_we  = hit;
        cnt_we = hit;
      end
      S_FCHK: begin
        bm_we     = bit_on;
        bm_waddr  = fw[WA_W-1:0];
        bm_wdata  = bm_rdata & ~(WORD_BITS'(1) << foff);
        cnt_we    = bit_on;
        cnt_waddr = fg[GA_W-1:0];
        cnt_wdata = (cnt_rdata == '0) ? '0 : cnt_rdata - COUNT_W'(1);
      end
      default: begin
        bm_we  = 1'b0;
        cnt_we = 1'b0;
      end
    endcase

    cnt_raddr = (state == S_FRD) ? fg[GA_W-1:0] : g[GA_W-1:0];
  end

  // bitmap and per-group counters
  always_ff @(posedge clk) begin
    if (bm_we) begin
      bitmap[bm_waddr] <= bm_wdata;
    end
    bm_rdata <= bitmap[bm_raddr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      group_cnt[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata <= group_cnt[cnt_raddr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      groups_in_use    <= GROUPS_RESET;
      first_free_inode <= FIRST_FREE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GROUPS:     groups_in_use    <= cfg_data[GROUPS_W-1:0];
        CFG_FIRST_FREE: first_free_inode <= cfg_data[INODE_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_ptr    <= '0;
      total_used <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      // a transfer empties the rsp register unless the output state refills it
      if (rsp.valid && rsp.ready && state != S_OUT) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_ptr <= clr_ptr + CP_W'(1);
          if (clr_ptr == CP_W'(CLR_N - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            mode_r <= req.mode;
            num_r  <= req.inode_number;
            state  <= S_LOAD;
          end
        end
        S_LOAD: begin
          ng_r <= ng_eff;
          cap  <= A_W'(ng_eff) * A_W'(INODES_PER_GROUP);
          // bit index to free, or the first bit past the reserved range
          if (mode_r == MODE_ALLOC) begin
            xs <= (first_free_inode == '0) ? '0 :
                  A_W'(first_free_inode - INODE_W'(1));
          end else begin
            xs <= A_W'(num_r - INODE_W'(1));
          end
          state <= S_CHECK;
        end
        S_CHECK: begin
          res_inode <= '0;
          if (mode_r == MODE_FREE) begin
            if (num_r < first_free_inode) begin
              res_status <= ST_RESERVED;
              state      <= S_OUT;
            end else if (num_r == '0 || A_W'(num_r) > cap) begin
              res_status <= ST_RANGE;
              state      <= S_OUT;
            end else begin
              state <= S_DG;
            end
          end else if (A_W'(total_used) >= cap) begin
            res_status <= ST_NONE;
            state      <= S_OUT;
          end else begin
            state <= S_DG;
          end
        end
        S_DG: state <= S_DW;
        S_DW: state <= S_CG;
        S_CG: begin
          fg    <= div_q;
          state <= S_CW;
        end
        S_CW: begin
          fw        <= div_q;
          foff      <= div_r[OFF_W-1:0];
          g         <= '0;
          base      <= '0;
          base_word <= '0;
          base_off  <= '0;
          state     <= (mode_r == MODE_FREE) ? S_FRD : S_GSEL;
        end
        S_FRD: state <= S_FCHK;
        S_FCHK: begin
          if (bit_on) begin
            res_status <= ST_OK;
            if (total_used != '0) begin
              total_used <= total_used - INODE_W'(1);
            end
          end else begin
            res_status <= ST_ALREADY;
          end
          state <= S_OUT;
        end
        S_GSEL: begin
          if (g >= ng_r) begin
            res_inode  <= '0;
            res_status <= ST_NONE;
            state      <= S_OUT;
          end else if (A_W'(g) < fg) begin
            // whole group lies in the reserved range
            g         <= g + GN_W'(1);
            base      <= base + A_W'(INODES_PER_GROUP);
            base_word <= nb_word;
            base_off  <= nb_off;
          end else begin
            state <= S_GCNT;
          end
        end
        S_GCNT: begin
          cnt_hold <= cnt_rdata;
          if (grp_full) begin
            g         <= g + GN_W'(1);
            base      <= base + A_W'(INODES_PER_GROUP);
            base_word <= nb_word;
            base_off  <= nb_off;
            state     <= S_GSEL;
          end else begin
            b_cur <= start_bit;
            w     <= start_word;
            woff  <= start_off;
            rem   <= start_rem;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            res_inode  <= INODE_W'(b_hit + A_W'(1));
            res_status <= ST_OK;
            total_used <= total_used + INODE_W'(1);
            state      <= S_OUT;
          end else if (rem_fits) begin
            // group exhausted, move on
            g         <= g + GN_W'(1);
            base      <= base + A_W'(INODES_PER_GROUP);
            base_word <= nb_word;
            base_off  <= nb_off;
            state     <= S_GSEL;
          end else begin
            b_cur <= b_cur + A_W'(avail);
            rem   <= rem - REM_W'(avail);
            woff  <= '0;
            w     <= w + A_W'(1);
          end
        end
        S_OUT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // response payload, loaded with the transfer slot
  always_ff @(posedge clk) begin
    if (state == S_OUT && (!rsp.valid || rsp.ready)) begin
      rsp.allocated_inode <= res_inode;
      rsp.status          <= res_status;
    end
  end

  `GBIA_ASSERT_IMPLY(a_fail_zero, clk, rst,
    rsp.valid && rsp.status != ST_OK, rsp.allocated_inode == '0,
    "failed result carries a number")
  `GBIA_ASSERT_IMPLY(a_div_ready, clk, rst,
    state == S_CG || state == S_CW, div_valid, "divider result late")
  `GBIA_ASSERT_IMPLY(a_scan_rem, clk, rst,
    state == S_SCAN, rem != '0, "scan window empty")
  `GBIA_ASSERT(a_rsp_from_out, clk, rst,
    $rose(rsp.valid) |-> $past(state) == S_OUT, "response raised outside output state")
  `GBIA_ASSERT(a_req_load, clk, rst,
    req.valid && req.ready |=> state == S_LOAD, "accepted request not loaded")

endmodule

[src/gbia_div.sv]
// two-stage divider by one of two constants, reciprocal multiply
module gbia_div #(
  parameter int N  = 24,
  parameter int D0 = 8192,
  parameter int D1 = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  gbia_pkg::div_ctl_t  ctl,
  input  logic [N-1:0]        x,
  output logic                valid,
  output logic [N-1:0]        q,
  output logic [N-1:0]        r
);
  import gbia_pkg::*;

  localparam int S0 = N + $clog2(D0);
  localparam int S1 = N + $clog2(D1);
  localparam int PW = 2 * N + 1;
  // rounded-up reciprocals, exact for every N-bit dividend
  localparam logic [63:0] M0 = ((64'd1 << S0) + 64'(D0) - 64'd1) / 64'(D0);
  localparam logic [63:0] M1 = ((64'd1 << S1) + 64'(D1) - 64'd1) / 64'(D1);

  logic          s1_valid;
  logic          s1_sel;
  logic [N-1:0]  s1_x;
  logic [PW-1:0] s1_prod;
  logic [N:0]    recip;
  logic [PW-1:0] qw;
  logic [N-1:0]  q_c;
  logic [N-1:0]  dsel;
  logic [N-1:0]  back;

  always_comb begin
    recip = (ctl.sel == DIV_WORD) ? M1[N:0] : M0[N:0];
    qw    = (s1_sel == DIV_WORD) ? (s1_prod >> S1) : (s1_prod >> S0);
    q_c   = qw[N-1:0];
    dsel  = (s1_sel == DIV_WORD) ? N'(D1) : N'(D0);
    back  = N'(q_c * dsel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      valid    <= 1'b0;
    end else begin
      s1_valid <= ctl.start;
      valid    <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_sel  <= ctl.sel;
    s1_x    <= x;
    s1_prod <= PW'(x) * PW'(recip);
    q       <= q_c;
    r       <= s1_x - back;
  end

endmodule
